// ===== src/oen_pkg.sv =====
// Shared constants for the onset envelope normaliser.
package oen_pkg;

    localparam int VALUE_WIDTH_DEF   = 24;
    localparam int HISTORY_DEPTH_DEF = 512;

    localparam int ENV_W   = 23;
    localparam int LEVEL_W = 16;

    localparam logic [ENV_W-1:0]   ENV_MAX   = {ENV_W{1'b1}};
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    // Weights 0.2 and 0.8 in units of 1/256.
    localparam int WEIGHT_W       = 8;
    localparam int ATTACK_WEIGHT  = 51;
    localparam int RELEASE_WEIGHT = 205;

    // Weighted sum of two 23-bit values by 8-bit weights, one guard bit.
    localparam int BLEND_W = ENV_W + WEIGHT_W + 1;

    // Partial remainder of the quotient unit: twice a value below the divisor.
    localparam int REM_W = ENV_W + 1;

endpackage

// ===== src/oen_if.sv =====
// Stream channels of the onset envelope normaliser: the onset input and the result output.
interface oen_in_if #(
    parameter int VALUE_WIDTH = oen_pkg::VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] onset_value;

    modport source (output valid, output onset_value, input ready);
    modport sink   (input valid, input onset_value, output ready);
endinterface

interface oen_out_if;
    logic                         valid;
    logic                         ready;
    logic [oen_pkg::ENV_W-1:0]    envelope;
    logic [oen_pkg::LEVEL_W-1:0]  normalized_level;

    modport source (output valid, output envelope, output normalized_level, input ready);
    modport sink   (input valid, input envelope, input normalized_level, output ready);
endinterface

// ===== src/onset_envelope_normalizer_top.sv =====
// Onset envelope normaliser: peak envelope, history ring, window maximum scan and serial divide.
//
//   Channel    Direction   Payload                                Beat
//   i_onset    in          onset_value (VALUE_WIDTH, signed)      valid & ready
//   o_result   out         envelope (23), normalized_level (16)   valid & ready
//
// The block takes no new input beat until the result of the last one is loaded into the
// output register; the serial scan of the history memory, one entry per cycle through its
// single read port, and the 16-step restoring divide make up most of that time.
// After reset the block clears the history memory, one entry a cycle, and takes no beat
// meanwhile. A result waits in the output register while o_result stalls; a finished
// quotient waits for that register to empty before it is loaded.
module onset_envelope_normalizer_top #(
    parameter int VALUE_WIDTH   = oen_pkg::VALUE_WIDTH_DEF,
    parameter int HISTORY_DEPTH = oen_pkg::HISTORY_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    oen_in_if.sink     i_onset,
    oen_out_if.source  o_result
);

    localparam int EnvW   = oen_pkg::ENV_W;
    localparam int LevelW = oen_pkg::LEVEL_W;
    localparam int BlendW = oen_pkg::BLEND_W;
    localparam int RemW   = oen_pkg::REM_W;
    localparam int MagW   = VALUE_WIDTH + EnvW;
    localparam int AddrW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CntW   = ($clog2(HISTORY_DEPTH + 1) > 5) ? $clog2(HISTORY_DEPTH + 1) : 5;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_BLEND = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_PREP  = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_PUT   = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic [AddrW-1:0]  r_idx, n_idx;
    logic [EnvW-1:0]   r_newest, n_newest;
    logic              r_rd_vld, n_rd_vld;
    logic              r_out_valid, n_out_valid;

    logic [EnvW-1:0]   r_mag, n_mag;
    logic [EnvW-1:0]   r_env, n_env;
    logic [EnvW-1:0]   r_peak, n_peak;
    logic [RemW-1:0]   r_div, n_div;
    logic [RemW-1:0]   r_rem, n_rem;
    logic [LevelW-1:0] r_quo, n_quo;
    logic              r_sat, n_sat;
    logic [EnvW-1:0]   r_out_env, n_out_env;
    logic [LevelW-1:0] r_out_level, n_out_level;

    logic [EnvW-1:0]   r_ring [HISTORY_DEPTH];
    logic [EnvW-1:0]   r_rd_data;

    logic              mem_we;
    logic [AddrW-1:0]  mem_waddr;
    logic [EnvW-1:0]   mem_wdata;

    logic                   in_beat;
    logic                   slot_free;
    logic [VALUE_WIDTH-1:0] abs_v;
    logic [MagW-1:0]        abs_x;
    logic [BlendW-1:0]      blend_sum;
    logic [EnvW-1:0]        blend;
    logic [AddrW-1:0]       idx_next;
    logic [RemW-1:0]        rem_dbl;

    assign i_onset.ready = (r_state == ST_IDLE);
    assign in_beat       = i_onset.valid && i_onset.ready;
    assign slot_free     = !r_out_valid || o_result.ready;

    assign o_result.valid            = r_out_valid;
    assign o_result.envelope         = r_out_env;
    assign o_result.normalized_level = r_out_level;

    // Magnitude in the input width; the most negative value wraps to its own unsigned magnitude.
    assign abs_v = i_onset.onset_value[VALUE_WIDTH-1]
                 ? (~i_onset.onset_value + VALUE_WIDTH'(1))
                 : i_onset.onset_value;
    assign abs_x = {{EnvW{1'b0}}, abs_v};

    assign blend_sum = BlendW'(oen_pkg::ATTACK_WEIGHT) * BlendW'(r_mag)
                     + BlendW'(oen_pkg::RELEASE_WEIGHT) * BlendW'(r_newest);
    assign blend     = blend_sum[oen_pkg::WEIGHT_W +: EnvW];

    assign idx_next = (r_idx == AddrW'(HISTORY_DEPTH - 1)) ? '0 : r_idx + AddrW'(1);
    assign rem_dbl  = {r_rem[RemW-2:0], 1'b0};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_newest    = r_newest;
        n_rd_vld    = 1'b0;
        n_out_valid = r_out_valid;
        n_mag       = r_mag;
        n_env       = r_env;
        n_peak      = r_peak;
        n_div       = r_div;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_sat       = r_sat;
        n_out_env   = r_out_env;
        n_out_level = r_out_level;
        mem_we      = 1'b0;
        mem_waddr   = r_cnt[AddrW-1:0];
        mem_wdata   = '0;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                n_cnt  = r_cnt + CntW'(1);
                if (r_cnt == CntW'(HISTORY_DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_beat) begin
                    n_mag   = (abs_x > MagW'(oen_pkg::ENV_MAX)) ? oen_pkg::ENV_MAX
                                                                : abs_x[EnvW-1:0];
                    n_state = ST_BLEND;
                end
            end
            ST_BLEND: begin
                n_env   = (blend > r_mag) ? blend : r_mag;
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = idx_next;
                mem_wdata = r_env;
                n_idx     = idx_next;
                n_newest  = r_env;
                n_cnt     = '0;
                n_peak    = '0;
                n_state   = ST_SCAN;
            end
            ST_SCAN: begin
                // Read data is registered, so the scan runs one count past the last address.
                if (r_rd_vld && (r_rd_data > r_peak)) begin
                    n_peak = r_rd_data;
                end
                n_rd_vld = (r_cnt < CntW'(HISTORY_DEPTH));
                n_cnt    = r_cnt + CntW'(1);
                if (r_cnt == CntW'(HISTORY_DEPTH)) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_div   = {1'b0, r_peak} + RemW'(1);
                n_rem   = {1'b0, r_env};
                n_sat   = ({1'b0, r_env} >= ({1'b0, r_peak} + RemW'(1)));
                n_quo   = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                // Restoring division, one quotient bit a cycle, most significant first.
                if (rem_dbl >= r_div) begin
                    n_rem = rem_dbl - r_div;
                    n_quo = {r_quo[LevelW-2:0], 1'b1};
                end else begin
                    n_rem = rem_dbl;
                    n_quo = {r_quo[LevelW-2:0], 1'b0};
                end
                n_cnt = r_cnt + CntW'(1);
                if (r_cnt == CntW'(LevelW - 1)) begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_env   = r_env;
                    n_out_level = r_sat ? oen_pkg::LEVEL_MAX : r_quo;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_newest    <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_newest    <= n_newest;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag       <= n_mag;
        r_env       <= n_env;
        r_peak      <= n_peak;
        r_div       <= n_div;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_sat       <= n_sat;
        r_out_env   <= n_out_env;
        r_out_level <= n_out_level;
    end

    // History memory: one write port, one registered read port swept by the scan counter.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_ring[r_cnt[AddrW-1:0]];
    end

    a_no_beat_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_onset.ready)
        else $error("input beat offered while the history memory is being cleared");

    a_env_not_below_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |-> (r_env >= r_mag))
        else $error("envelope fell below the input magnitude");

    a_peak_covers_env: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PREP) |-> (r_peak >= r_env))
        else $error("window maximum missed the newest envelope");

    a_div_leads_to_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == CntW'(LevelW - 1)) |=> (r_state == ST_PUT))
        else $error("divider did not finish after its last quotient bit");

endmodule

// ===== tb/sv/oen_checker.sv =====
// Scoreboard for the onset envelope normaliser: predicts each result beat and compares it.
module oen_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    oen_in_if    i_onset,
    oen_out_if   o_result,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int VW    = oen_pkg::VALUE_WIDTH_DEF;
    localparam int DEPTH = oen_pkg::HISTORY_DEPTH_DEF;

    typedef struct packed {
        logic [oen_pkg::ENV_W-1:0]   envelope;
        logic [oen_pkg::LEVEL_W-1:0] level;
    } t_envelope_level;

    logic [oen_pkg::ENV_W-1:0] env_ring [DEPTH];
    int                        newest_slot;
    t_envelope_level           awaited_levels [$];
    int                        fail_count;

    // Advances the envelope follower by one onset value and returns the beat it should give.
    function automatic t_envelope_level follow_onset(input logic [VW-1:0] raw);
        logic [VW:0]               mag_full;
        logic [oen_pkg::ENV_W-1:0] mag;
        logic [oen_pkg::ENV_W-1:0] prev;
        logic [oen_pkg::ENV_W-1:0] env;
        logic [oen_pkg::ENV_W-1:0] peak;
        logic [63:0]               blend;
        logic [63:0]               quo;
        t_envelope_level           res;
        mag_full = raw[VW-1] ? ({1'b1, {VW{1'b0}}} - {1'b0, raw}) : {1'b0, raw};
        mag      = (mag_full > (VW+1)'(oen_pkg::ENV_MAX)) ? oen_pkg::ENV_MAX
                                                          : mag_full[oen_pkg::ENV_W-1:0];
        prev     = env_ring[newest_slot];
        blend    = (64'(oen_pkg::ATTACK_WEIGHT) * 64'(mag)
                  + 64'(oen_pkg::RELEASE_WEIGHT) * 64'(prev)) >> oen_pkg::WEIGHT_W;
        env      = (blend > 64'(mag)) ? blend[oen_pkg::ENV_W-1:0] : mag;
        newest_slot = (newest_slot + 1) % DEPTH;
        env_ring[newest_slot] = env;
        peak = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (env_ring[k] > peak) begin
                peak = env_ring[k];
            end
        end
        // The extra LSB on the divisor keeps an all-zero window from dividing by zero.
        quo = (64'(env) << oen_pkg::LEVEL_W) / (64'(peak) + 64'd1);
        res.envelope = env;
        res.level    = (quo > 64'(oen_pkg::LEVEL_MAX)) ? oen_pkg::LEVEL_MAX
                                                       : quo[oen_pkg::LEVEL_W-1:0];
        return res;
    endfunction

    task automatic note_failure(input string what, input t_envelope_level want,
                                input t_envelope_level got);
        if (fail_count < 10) begin
            $display("%0t: %s: expected envelope %0d level %0d, got envelope %0d level %0d",
                     $realtime, what, want.envelope, want.level, got.envelope, got.level);
        end
        fail_count++;
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_envelope_level want;
        t_envelope_level got;
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                env_ring[k] = '0;
            end
            newest_slot = 0;
            awaited_levels.delete();
            fail_count = 0;
        end else begin
            // Retire the result beat first so that a beat nobody asked for is not hidden
            // behind an expectation pushed at the same edge.
            if (o_result.valid && o_result.ready) begin
                got.envelope = o_result.envelope;
                got.level    = o_result.normalized_level;
                if (awaited_levels.size() == 0) begin
                    note_failure("result beat with nothing expected", '0, got);
                end else begin
                    want = awaited_levels.pop_front();
                    if (got.envelope !== want.envelope || got.level !== want.level) begin
                        note_failure("result mismatch", want, got);
                    end
                end
            end
            if (i_onset.valid && i_onset.ready) begin
                awaited_levels.push_back(follow_onset(i_onset.onset_value));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= awaited_levels.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the onset envelope normaliser testbench: clock, reset, stimulus, receiver and verdict.
module tb;

    localparam int VW = oen_pkg::VALUE_WIDTH_DEF;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   burst_left;

    oen_in_if  u_onset_ch ();
    oen_out_if u_result_ch ();

    onset_envelope_normalizer_top u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_onset  (u_onset_ch),
        .o_result (u_result_ch)
    );

    oen_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_onset      (u_onset_ch),
        .o_result     (u_result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offers one onset beat, opening a new burst after a random gap when the last one is spent.
    task automatic send_onset(input logic [VW-1:0] value);
        int gap;
        int pick;
        if (burst_left == 0) begin
            pick = $urandom_range(9, 0);
            if (pick < 4) begin
                gap = 0;
            end else if (pick < 7) begin
                gap = $urandom_range(20, 1);
            end else begin
                gap = $urandom_range(700, 21);
            end
            if (gap > 0) begin
                u_onset_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(8, 1);
        end
        burst_left--;
        u_onset_ch.valid       <= 1'b1;
        u_onset_ch.onset_value <= value;
        do @(posedge clk); while (!u_onset_ch.ready);
    endtask

    // Signed value whose magnitude fits in the given number of bits; 24 means any pattern.
    function automatic logic [VW-1:0] scaled_onset(input int bits);
        logic [VW-1:0] v;
        v = VW'($urandom());
        if (bits < VW) begin
            v = v & ((VW'(1) << bits) - VW'(1));
            if ($urandom_range(1, 0) == 1) begin
                v = -v;
            end
        end
        return v;
    endfunction

    function automatic logic [VW-1:0] busy_onset();
        int pick;
        pick = $urandom_range(49, 0);
        if (pick == 0) begin
            return {1'b1, {(VW-1){1'b0}}};
        end else if (pick == 1) begin
            return {1'b0, {(VW-1){1'b1}}};
        end else if (pick == 2) begin
            return '0;
        end
        return scaled_onset($urandom_range(VW, 0));
    endfunction

    // Receiver: one long hold-off so that the block backs up into its input, then a mix of
    // stall patterns.
    initial begin : receiver
        int held;
        int mode;
        int run;
        int period;
        u_result_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        held = 0;
        while (held < 3000) begin
            @(posedge clk);
            held++;
        end
        forever begin
            mode   = $urandom_range(3, 0);
            run    = $urandom_range(400, 20);
            period = $urandom_range(6, 2);
            for (int c = 0; c < run; c++) begin
                case (mode)
                    0: begin
                        u_result_ch.ready <= 1'b1;
                    end
                    1: begin
                        u_result_ch.ready <= 1'($urandom_range(1, 0));
                    end
                    2: begin
                        u_result_ch.ready <= ($urandom_range(7, 0) == 0);
                    end
                    default: begin
                        u_result_ch.ready <= ((c % period) != 0);
                    end
                endcase
                @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        logic [VW-1:0] directed [$];
        rst_n                  = 1'b0;
        u_onset_ch.valid       = 1'b0;
        u_onset_ch.onset_value = '0;
        burst_left             = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Zero into an empty window first, then the extremes, then a decay after a peak.
        directed = '{24'sd0, 24'sd1, 24'sd2, -24'sd1, -24'sd2, 24'sd8388607, 24'h800000,
                     -24'sd8388607, 24'sd0, 24'sd0, 24'sd0, 24'sd4194304, -24'sd4194304,
                     24'sd100, -24'sd100, 24'sd8388606, 24'h555555, 24'hAAAAAA, 24'sd7,
                     24'sd12345, -24'sd12345, 24'sd0, 24'sd0};
        foreach (directed[k]) begin
            send_onset(directed[k]);
        end

        // Loud, then a quiet stretch longer than the ring so earlier peaks age out, then loud.
        for (int k = 0; k < 1000; k++) begin
            if (k >= 250 && k < 850) begin
                send_onset(scaled_onset($urandom_range(10, 0)));
            end else begin
                send_onset(busy_onset());
            end
        end
        u_onset_ch.valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #60000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
